/* rtl/core/nand_ftl_logical_map_builder_defines.svh */
// Assertion macros for the logical map builder.
// Depends on nothing; included by the top level only.
`ifndef NAND_FTL_LOGICAL_MAP_BUILDER_DEFINES_SVH
`define NAND_FTL_LOGICAL_MAP_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NFLM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NFLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/nflm_pkg.sv */
// Shared types, codes and sizes for the logical map builder.
// No dependencies; imported by every module of the block.
package nflm_pkg;

  localparam int LOGICAL_ENTRIES = 1024;
  localparam int PHYS_BLOCKS     = 1024;
  localparam int MAP_AW          = $clog2(LOGICAL_ENTRIES);
  localparam int CFG_DW          = 16;

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SCAN   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // scan status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISAGREE = 3'd1;
  localparam logic [2:0] ST_PARITY   = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_SKIPPED  = 3'd4;

  // lookup status
  localparam logic [2:0] LK_MAPPED   = 3'd0;
  localparam logic [2:0] LK_UNMAPPED = 3'd1;
  localparam logic [2:0] LK_RANGE    = 3'd2;

  // configuration register indexes
  localparam logic CFG_LOGICAL_LIMIT = 1'b0;
  localparam logic CFG_RESERVED_CODE = 1'b1;

  localparam logic [10:0] LOGICAL_LIMIT_RST = 11'd424;
  localparam logic [15:0] RESERVED_CODE_RST = 16'hFFFF;

  typedef logic [MAP_AW-1:0] map_addr_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] phys_block;
    logic       block_bad;
    logic       spare_read_ok;
    logic [7:0] copy_a_low;
    logic [7:0] copy_a_high;
    logic [7:0] copy_b_low;
    logic [7:0] copy_b_high;
    logic [7:0] copy_c_low;
    logic [7:0] copy_c_high;
    logic [9:0] query_logical;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       entry_written;
    logic [9:0] decoded_logical;
    logic [9:0] mapped_phys;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [9:0] phys;
  } map_entry_t;

  // tag decode summary handed from the decoder to the pipeline
  typedef struct packed {
    logic [2:0] scan_status;
    logic [9:0] decoded;
    logic       in_map;     // scan: write candidate; lookup: index in range
    map_addr_t  map_addr;
  } dec_info_t;

  typedef enum logic [1:0] {
    SW_IDLE = 2'b01,
    SW_RUN  = 2'b10
  } sweep_state_t;

endpackage

/* rtl/core/nflm_tag_decode.sv */
// Tag vote, parity and reserved check, range check and map address.
// Depends on nflm_pkg.
module nflm_tag_decode import nflm_pkg::*; (
  input  cmd_t        cmd,
  input  logic [10:0] logical_limit,
  input  logic [15:0] reserved_code,
  output dec_info_t   info
);

  logic [15:0] tag_a, tag_b, tag_c, tag;
  logic        agree, skip;
  logic [2:0]  scan_status;
  logic [9:0]  decoded, lg;
  logic        lg_ok;

  assign tag_a = {cmd.copy_a_high, cmd.copy_a_low};
  assign tag_b = {cmd.copy_b_high, cmd.copy_b_low};
  assign tag_c = {cmd.copy_c_high, cmd.copy_c_low};

  assign skip = cmd.block_bad || !cmd.spare_read_ok ||
                (32'(cmd.phys_block) >= PHYS_BLOCKS);

  // first agreeing pair wins: A/B, B/C, C/A
  always_comb begin
    agree = 1'b1;
    if (tag_a == tag_b) begin
      tag = tag_a;
    end else if (tag_b == tag_c) begin
      tag = tag_b;
    end else if (tag_c == tag_a) begin
      tag = tag_c;
    end else begin
      tag   = '0;
      agree = 1'b0;
    end
  end

  always_comb begin
    if (skip) begin
      scan_status = ST_SKIPPED;
    end else if (!agree) begin
      scan_status = ST_DISAGREE;
    end else if (^tag) begin
      scan_status = ST_PARITY;
    end else if (tag == reserved_code) begin
      scan_status = ST_RESERVED;
    end else begin
      scan_status = ST_OK;
    end
  end

  assign info.scan_status = scan_status;

  assign decoded      = (scan_status == ST_OK) ? tag[10:1] : '0;
  assign info.decoded = decoded;

  assign lg    = (cmd.opcode == OP_SCAN) ? decoded : cmd.query_logical;
  assign lg_ok = ({1'b0, lg} < logical_limit) && (32'(lg) < LOGICAL_ENTRIES);

  assign info.in_map = (cmd.opcode == OP_SCAN) ?
                       ((scan_status == ST_OK) && (decoded != '0) && lg_ok) :
                       lg_ok;
  assign info.map_addr = lg[MAP_AW-1:0];

endmodule

/* rtl/core/nflm_map_mem.sv */
// Map storage: valid bit and physical block per logical entry.
// One write port, one registered read port; depends on nflm_pkg.
module nflm_map_mem import nflm_pkg::*; (
  input  logic       clk,
  input  logic       we,
  input  map_addr_t  waddr,
  input  map_entry_t wdata,
  input  map_addr_t  raddr,
  output map_entry_t rdata
);

  map_entry_t mem [LOGICAL_ENTRIES];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/nand_ftl_logical_map_builder.sv */
// Top level of the NAND logical-to-physical map builder.
// Depends on nflm_pkg, nflm_tag_decode, nflm_map_mem and the defines header.
`include "nand_ftl_logical_map_builder_defines.svh"

// Usage: a command beat is taken on a clock edge with start high and busy low,
// and its one result beat shows on result with result_valid high for exactly
// one cycle, after passing the stage 1, stage 2 and result registers. Results
// cannot be stalled: the receiver must take every result in its cycle. Scan
// and lookup commands can be issued every cycle while busy is low; the map
// memory's one read and one write port carry one read-modify-write per cycle,
// with a bypass so back-to-back scans and lookups of the same entry see each
// other. A clear command holds busy high while it is in stages 1 and 2 and
// then through a sweep over all LOGICAL_ENTRIES (1024) entries that zeroes
// the valid bits, one entry per cycle. The same sweep runs after reset, so
// busy stays high after rst falls until it ends. Configuration writes (cfg_we)
// land at once and may be issued any time the block is idle, busy or not.
module nand_ftl_logical_map_builder import nflm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  output logic              result_valid,
  output result_t           result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  // config registers
  logic [10:0] logical_limit;
  logic [15:0] reserved_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      logical_limit <= LOGICAL_LIMIT_RST;
      reserved_code <= RESERVED_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOGICAL_LIMIT: logical_limit <= cfg_data[10:0];
        CFG_RESERVED_CODE: reserved_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: command register + tag decode ----------------
  logic      accept;
  logic      s1_valid;
  cmd_t      s1_cmd;
  dec_info_t dec;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd;
    end
  end

  nflm_tag_decode u_dec (
    .cmd           (s1_cmd),
    .logical_limit (logical_limit),
    .reserved_code (reserved_code),
    .info          (dec)
  );

  // ---------------- stage 2: map read data + update ----------------
  logic       s2_valid;
  logic [1:0] s2_op;
  logic [2:0] s2_status;
  logic [9:0] s2_decoded;
  logic       s2_in_map;
  logic [9:0] s2_phys;
  map_addr_t  s2_addr;
  logic       s2_fwd;
  logic [9:0] s2_fwd_phys;
  logic       s2_we;
  map_entry_t rd_entry;
  logic       cur_valid;
  logic [9:0] cur_phys;

  // bypass: the entry stage 2 writes this edge is the one stage 1 reads
  logic fwd_hit;
  assign fwd_hit = s2_we && (s2_addr == dec.map_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_op       <= s1_cmd.opcode;
    s2_status   <= dec.scan_status;
    s2_decoded  <= dec.decoded;
    s2_in_map   <= dec.in_map;
    s2_phys     <= s1_cmd.phys_block;
    s2_addr     <= dec.map_addr;
    s2_fwd      <= fwd_hit;
    s2_fwd_phys <= s2_phys;
  end

  assign cur_valid = s2_fwd || rd_entry.valid;
  assign cur_phys  = s2_fwd ? s2_fwd_phys : rd_entry.phys;
  assign s2_we     = s2_valid && (s2_op == OP_SCAN) && s2_in_map && !cur_valid;

  // ---------------- clear sweep ----------------
  sweep_state_t sweep_state;
  map_addr_t    sweep_cnt;
  logic         sweeping;

  assign sweeping = (sweep_state == SW_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_state <= SW_RUN;
      sweep_cnt   <= '0;
    end else begin
      unique case (sweep_state)
        SW_IDLE: begin
          if (s2_valid && (s2_op == OP_CLEAR)) begin
            sweep_state <= SW_RUN;
            sweep_cnt   <= '0;
          end
        end
        SW_RUN: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == MAP_AW'(LOGICAL_ENTRIES - 1)) begin
            sweep_state <= SW_IDLE;
          end
        end
        default: sweep_state <= SW_IDLE;
      endcase
    end
  end

  // a clear in flight or a running sweep holds off new commands
  assign busy = sweeping ||
                (s1_valid && (s1_cmd.opcode == OP_CLEAR)) ||
                (s2_valid && (s2_op == OP_CLEAR));

  // ---------------- map memory ----------------
  logic       mem_we;
  map_addr_t  mem_waddr;
  map_entry_t mem_wdata;

  assign mem_we    = sweeping || s2_we;
  assign mem_waddr = sweeping ? sweep_cnt : s2_addr;
  assign mem_wdata = sweeping ? map_entry_t'{valid: 1'b0, phys: '0} :
                                map_entry_t'{valid: 1'b1, phys: s2_phys};

  nflm_map_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (dec.map_addr),
    .rdata (rd_entry)
  );

  // ---------------- stage 3: result register ----------------
  result_t res_next;

  always_comb begin
    res_next = '0;
    unique case (s2_op)
      OP_SCAN: begin
        res_next.status          = s2_status;
        res_next.entry_written   = s2_we;
        res_next.decoded_logical = s2_decoded;
      end
      OP_LOOKUP: begin
        if (!s2_in_map) begin
          res_next.status = LK_RANGE;
        end else if (!cur_valid) begin
          res_next.status = LK_UNMAPPED;
        end else begin
          res_next.status      = LK_MAPPED;
          res_next.mapped_phys = cur_phys;
        end
      end
      default: ;  // clear and unused codes: all zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // ---------------- assertions ----------------
  `NFLM_ASSERT_IMPL(a_result_latency, clk, rst, accept, ##3 result_valid,
                    "accepted beat produced no result")
  `NFLM_ASSERT_IMPL(a_write_is_valid_tag, clk, rst, result_valid && result.entry_written,
                    (result.status == ST_OK) && (result.decoded_logical != '0),
                    "map write on a rejected tag")
  `NFLM_ASSERT_NEXT(a_no_result_in_sweep, clk, rst, sweeping && (sweep_cnt != '0),
                    !result_valid, "result during clear sweep")
  `NFLM_ASSERT_IMPL(a_no_write_collision, clk, rst, sweeping, !s2_we,
                    "scan write during clear sweep")

endmodule

/* tb/sv/nand_ftl_logical_map_builder_test.sv */
// Self-checking testbench for nand_ftl_logical_map_builder: directed and random
// clear/scan/lookup beats checked against an in-bench map predictor.
// Depends on nflm_pkg and the block's RTL only.
import nflm_pkg::*;

// Map predictor plus queue of pending result beats.
class map_scoreboard;
  logic [10:0] map_limit;
  logic [15:0] reserved_tag;
  bit          slot_used [LOGICAL_ENTRIES];
  logic [9:0]  slot_phys [LOGICAL_ENTRIES];
  result_t     expected_results [$];
  int          mismatches;
  int          commands_seen;
  int          entries_written;
  int          lookups_hit;
  int          clears_seen;

  function new();
    map_limit       = LOGICAL_LIMIT_RST;
    reserved_tag    = RESERVED_CODE_RST;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    mismatches      = 0;
    commands_seen   = 0;
    entries_written = 0;
    lookups_hit     = 0;
    clears_seen     = 0;
  endfunction

  function bit in_window(logic [9:0] lg);
    return int'(lg) < int'(map_limit) && int'(lg) < LOGICAL_ENTRIES;
  endfunction

  // Work out the result of one accepted command beat and queue it.
  function void note_command(cmd_t c);
    result_t     r;
    logic [15:0] a, b, cc, tag;
    logic [9:0]  lg;
    bit          agree;
    r = '0;
    commands_seen++;
    case (c.opcode)
      OP_CLEAR: begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        clears_seen++;
      end
      OP_SCAN: begin
        if (c.block_bad || !c.spare_read_ok || int'(c.phys_block) >= PHYS_BLOCKS) begin
          r.status = ST_SKIPPED;
        end else begin
          a     = {c.copy_a_high, c.copy_a_low};
          b     = {c.copy_b_high, c.copy_b_low};
          cc    = {c.copy_c_high, c.copy_c_low};
          agree = 1'b1;
          tag   = '0;
          // first agreeing pair wins: A/B, then B/C, then C/A
          if (a == b) tag = a;
          else if (b == cc) tag = b;
          else if (cc == a) tag = cc;
          else agree = 1'b0;
          if (!agree) begin
            r.status = ST_DISAGREE;
          end else if (^tag) begin
            r.status = ST_PARITY;
          end else if (tag == reserved_tag) begin
            r.status = ST_RESERVED;
          end else begin
            lg = tag[10:1];
            r.status = ST_OK;
            r.decoded_logical = lg;
            if (lg != 0 && in_window(lg) && !slot_used[lg]) begin
              slot_used[lg] = 1'b1;
              slot_phys[lg] = c.phys_block;
              r.entry_written = 1'b1;
              entries_written++;
            end
          end
        end
      end
      OP_LOOKUP: begin
        if (!in_window(c.query_logical)) begin
          r.status = LK_RANGE;
        end else if (!slot_used[c.query_logical]) begin
          r.status = LK_UNMAPPED;
        end else begin
          r.status = LK_MAPPED;
          r.mapped_phys = slot_phys[c.query_logical];
          lookups_hit++;
        end
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endfunction

  // Compare one result beat against the oldest expectation.
  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: %h", got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.entry_written !== want.entry_written) begin
      $error("entry_written: expected %0d, got %0d", want.entry_written, got.entry_written);
      mismatches++;
    end
    if (got.decoded_logical !== want.decoded_logical) begin
      $error("decoded_logical: expected %0d, got %0d",
             want.decoded_logical, got.decoded_logical);
      mismatches++;
    end
    if (got.mapped_phys !== want.mapped_phys) begin
      $error("mapped_phys: expected %0d, got %0d", want.mapped_phys, got.mapped_phys);
      mismatches++;
    end
  endfunction
endclass

module nand_ftl_logical_map_builder_test;

  // Cycles to keep waiting once results are in and busy is low when draining.
  localparam int DRAIN_CYCLES    = 8;
  // Longest quiet stretch of a correct run is a clear with its sweep or the
  // post-reset sweep, so this leaves a wide margin.
  localparam int WATCHDOG_CYCLES = 6000;
  localparam int PHASE_ITEMS     = 245;

  // How the three tag copies relate to each other in a scan beat.
  typedef enum int {
    AGREE_ALL,
    AGREE_AB,
    AGREE_BC,
    AGREE_CA,
    AGREE_NONE
  } copy_match_e;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              busy;
  cmd_t              cmd       = '0;
  logic              result_valid;
  result_t           result;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_DW-1:0] cfg_data  = '0;

  map_scoreboard sb;
  int            quiet_cycles = 0;
  int            settings_applied = 0;

  always #4 clk = ~clk;

  nand_ftl_logical_map_builder DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Monitor: everything is sampled at the edge, so values read here are the
  // ones the block saw. Results are checked before the new beat is noted; a
  // result can never belong to a beat taken on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(result);
      if (start && !busy) sb.note_command(cmd);
      if (result_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Hold a command beat on the bus until the block takes it. start stays high
  // on return so back-to-back beats need no extra assignment.
  task automatic send_command(cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  // Stop issuing, let every expected result arrive and any clear sweep finish.
  task automatic wait_until_drained();
    start <= 1'b0;
    while (sb.expected_results.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers change only with the block idle.
  task automatic apply_settings(logic [10:0] limit, logic [15:0] code);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOGICAL_LIMIT;
    cfg_data  <= {5'd0, limit};
    @(posedge clk);
    cfg_index <= CFG_RESERVED_CODE;
    cfg_data  <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.map_limit    = limit;
    sb.reserved_tag = code;
    settings_applied++;
  endtask

  // Tag with the logical number in bits 10..1, random upper bits, and bit 0
  // chosen for even (or deliberately odd) parity.
  function automatic logic [15:0] make_tag(logic [9:0] lg, bit odd);
    logic [15:0] t;
    t       = 16'($urandom);
    t[10:1] = lg;
    t[0]    = (^t[15:1]) ^ odd;
    return t;
  endfunction

  // Reserved code with even parity, so the reserved check stays reachable.
  function automatic logic [15:0] random_code();
    logic [15:0] t;
    t    = 16'($urandom);
    t[0] = ^t[15:1];
    return t;
  endfunction

  // Spread a tag over the three copies in the given agreement pattern.
  function automatic cmd_t with_tag(cmd_t c, logic [15:0] tag, copy_match_e m);
    logic [15:0] a, b, cc, x, y;
    x = 16'($urandom_range(1, 65535));
    do y = 16'($urandom_range(1, 65535)); while (y == x);
    case (m)
      AGREE_ALL: begin
        a = tag; b = tag; cc = tag;
      end
      AGREE_AB: begin
        a = tag; b = tag; cc = tag ^ x;
      end
      AGREE_BC: begin
        a = tag ^ x; b = tag; cc = tag;
      end
      AGREE_CA: begin
        a = tag; b = tag ^ x; cc = tag;
      end
      default: begin
        a = tag; b = tag ^ x; cc = tag ^ y;
      end
    endcase
    c.opcode      = OP_SCAN;
    c.copy_a_low  = a[7:0];
    c.copy_a_high = a[15:8];
    c.copy_b_low  = b[7:0];
    c.copy_b_high = b[15:8];
    c.copy_c_low  = cc[7:0];
    c.copy_c_high = cc[15:8];
    return c;
  endfunction

  function automatic cmd_t scan_cmd(logic [9:0] phys, bit bad, bit rok,
                                    logic [15:0] tag, copy_match_e m);
    cmd_t c;
    c               = '0;
    c.phys_block    = phys;
    c.block_bad     = bad;
    c.spare_read_ok = rok;
    return with_tag(c, tag, m);
  endfunction

  function automatic cmd_t lookup_cmd(logic [9:0] q);
    cmd_t c;
    c               = '0;
    c.opcode        = OP_LOOKUP;
    c.query_logical = q;
    return c;
  endfunction

  // Logical numbers: mostly a small pool inside the window so entries get
  // hit again (already-set, mapped lookups), the rest spread wide.
  function automatic logic [9:0] pick_logical();
    int lim, span, roll;
    lim  = sb.map_limit;
    span = (lim > 1) ? ((lim - 1 < 63) ? lim - 1 : 63) : 1;
    roll = $urandom_range(99);
    if (roll < 60) return 10'($urandom_range(1, span));
    if (roll < 80) return 10'($urandom_range(0, (lim > 1) ? lim - 1 : 0));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Random beats: unused fields carry noise, scans are mostly well-formed
  // tags, the rest parity errors, reserved tags, disagreeing or raw copies.
  task automatic run_phase(int items, int idle_pct);
    cmd_t        c;
    logic [95:0] noise;
    int          roll, gap, calm_left;
    calm_left = 0;
    for (int i = 0; i < items; i++) begin
      noise = {$urandom, $urandom, $urandom};
      c     = noise[$bits(cmd_t)-1:0];
      roll  = $urandom_range(99);
      if (roll < 2) begin
        c.opcode = OP_CLEAR;
      end else if (roll < 40) begin
        c.opcode        = OP_LOOKUP;
        c.query_logical = pick_logical();
      end else begin
        c.block_bad     = ($urandom_range(9) == 0);
        c.spare_read_ok = ($urandom_range(9) != 0);
        roll = $urandom_range(99);
        if (roll < 70)
          c = with_tag(c, make_tag(pick_logical(), 1'b0), copy_match_e'($urandom_range(3)));
        else if (roll < 80)
          c = with_tag(c, make_tag(pick_logical(), 1'b1), copy_match_e'($urandom_range(3)));
        else if (roll < 87)
          c = with_tag(c, sb.reserved_tag, copy_match_e'($urandom_range(3)));
        else if (roll < 95)
          c = with_tag(c, make_tag(pick_logical(), 1'b0), AGREE_NONE);
        else
          c.opcode = OP_SCAN;
      end
      send_command(c);
      // idle gaps cover every stage of the 3-deep pipeline;
      // occasional calm stretches keep full-rate bursts in every phase
      gap = 0;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(49) == 0) calm_left = 30;
      else if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at reset settings (limit 424, reserved 0xFFFF).
    send_command(lookup_cmd(10'd0));          // empty map
    send_command(lookup_cmd(10'd423));        // last in-window entry
    send_command(lookup_cmd(10'd424));        // at limit: out of range
    send_command(lookup_cmd(10'd1023));
    send_command(scan_cmd(10'd1023, 1'b0, 1'b1, make_tag(10'd5, 1'b0), AGREE_ALL));
    send_command(lookup_cmd(10'd5));          // mapped to 1023
    send_command(scan_cmd(10'd7, 1'b0, 1'b1, make_tag(10'd5, 1'b0), AGREE_AB)); // already set
    send_command(scan_cmd(10'd0, 1'b0, 1'b1, make_tag(10'd1, 1'b0), AGREE_AB));
    send_command(scan_cmd(10'd512, 1'b0, 1'b1, make_tag(10'd423, 1'b0), AGREE_BC));
    send_command(scan_cmd(10'd300, 1'b0, 1'b1, make_tag(10'd424, 1'b0), AGREE_CA));
    send_command(scan_cmd(10'd9, 1'b0, 1'b1, 16'h0000, AGREE_ALL));  // decodes to 0
    send_command(scan_cmd(10'd10, 1'b0, 1'b1, make_tag(10'd9, 1'b0), AGREE_NONE));
    send_command(scan_cmd(10'd11, 1'b0, 1'b1, make_tag(10'd9, 1'b1), AGREE_ALL));
    send_command(scan_cmd(10'd12, 1'b0, 1'b1, 16'hFFFF, AGREE_AB));  // reserved
    send_command(scan_cmd(10'd13, 1'b1, 1'b1, make_tag(10'd2, 1'b0), AGREE_ALL));
    send_command(scan_cmd(10'd14, 1'b0, 1'b0, make_tag(10'd2, 1'b0), AGREE_ALL));
    send_command(scan_cmd(10'd15, 1'b1, 1'b0, make_tag(10'd2, 1'b0), AGREE_ALL));
    send_command(lookup_cmd(10'd1));          // mapped to 0
    send_command(lookup_cmd(10'd423));        // mapped to 512
    send_command('0);                         // clear
    send_command(lookup_cmd(10'd5));          // unmapped after clear
    send_command(scan_cmd(10'd1023, 1'b0, 1'b1, make_tag(10'd1023, 1'b0), AGREE_ALL));
    send_command(lookup_cmd(10'd2));

    // Random phases over several settings, extremes first.
    apply_settings(11'd1024, 16'h0000);
    run_phase(PHASE_ITEMS, 0);
    apply_settings(11'd1, 16'hFFFF);
    run_phase(PHASE_ITEMS, 64);
    apply_settings(11'($urandom_range(1, 1024)), random_code());
    run_phase(PHASE_ITEMS, 0);
    apply_settings(11'd424, 16'hFFFF);
    run_phase(PHASE_ITEMS, 17);
    apply_settings(11'($urandom_range(1, 1024)), random_code());
    run_phase(PHASE_ITEMS, 64);

    wait_until_drained();
    if (sb.expected_results.size() != 0) begin
      $error("%0d result beats never arrived", sb.expected_results.size());
      sb.mismatches++;
    end

    $display("covered %0d command beats under %0d register settings",
             sb.commands_seen, settings_applied + 1);
    $display("map writes %0d, mapped lookups %0d, clears %0d, mismatches %0d",
             sb.entries_written, sb.lookups_hit, sb.clears_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
